// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Relies on signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define LNDR_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LNDR_CHECK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lndr_pkg.sv =====
// Shared types and constants for the nondecreasing run tracker.
// No dependencies.
package lndr_pkg;

  localparam int OUT_W = 16;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Control for the shared max unit.
  typedef struct packed {
    logic clr;  // restart the running peak at zero
    logic acc;  // fold the RAM read data into the peak
  } max_ctl_t;

endpackage

// ===== sv/lndr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lndr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lndr_max_unit.sv =====
// Shared compare unit: running maximum over streamed table entries,
// plus the saturating increment of that maximum. Uses lndr_pkg.
module lndr_max_unit #(
  parameter int LEN_BITS = 16
) (
  input  logic                 clk,
  input  lndr_pkg::max_ctl_t   ctl,
  input  logic [LEN_BITS-1:0]  data,
  output logic [LEN_BITS-1:0]  peak,
  output logic [LEN_BITS-1:0]  fresh
);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      peak <= '0;
    end else if (ctl.acc && (data > peak)) begin
      peak <= data;
    end
  end

  // saturate at all ones
  assign fresh = (&peak) ? peak : peak + LEN_BITS'(1);

endmodule

// ===== sv/longest_nondecreasing_run_tracker_unit.sv =====
// Longest nondecreasing subsequence tracker: top level.
// Uses lndr_pkg, lndr_ram, lndr_max_unit and assert_macros.svh.
//
// Each input beat carries a value and a start flag; each produces one output
// beat with the longest nondecreasing subsequence length seen so far. A table
// in RAM holds, per value, the best length of a run ending in that value. For
// a value v (clamped to VALUES-1) the sequencer reads entries 0..v one per
// cycle through the single RAM read port into the shared max unit, then
// writes peak+1 (saturating) back to entry v and updates the running maximum.
// A normal beat runs from acceptance to the next possible acceptance through
// the scan state (v+1 reads), the drain state for the read latency, the
// write state and the idle state. A beat with start_req set sweeps the whole
// table to zero instead of scanning and always reports 1. After reset the
// same sweep runs before the first beat is taken. The output register holds
// a finished result while the next beat is accepted and worked on; the block
// only waits in its write state if the previous result has still not been
// taken. Lengths saturate at 2^LEN_BITS-1, and the longest port saturates
// at 65535.
module longest_nondecreasing_run_tracker_unit #(
  parameter int VALUES   = 256,
  parameter int LEN_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                value,
  input  logic                      start_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lndr_pkg::OUT_W-1:0] longest
);

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(VALUES);
  // wide enough for both the 8-bit value and the count VALUES itself
  localparam int WW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(VALUES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,  // zero sweep over the table
    S_IDLE,   // ready for a beat
    S_SCAN,   // issue reads 0..idx
    S_DRAIN,  // last read data lands in the max unit
    S_WRITE   // write back, update maximum, load output
  } state_t;

  state_t              state;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    cnt;
  logic                rd_vld;
  logic                from_start;   // sweep belongs to a start beat
  logic [LEN_BITS-1:0] overall_best;

  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;
  logic [WW-1:0]         value_ext;
  logic [IDX_W-1:0]      idx_in;
  logic                  mem_wr;
  logic [IDX_W-1:0]      mem_waddr;
  logic [LEN_BITS-1:0]   mem_wdata;
  logic                  mem_rd;
  logic [LEN_BITS-1:0]   mem_rdata;
  logic [LEN_BITS-1:0]   peak;
  logic [LEN_BITS-1:0]   fresh;
  logic [LEN_BITS-1:0]   overall_best_next;
  logic [lndr_pkg::OUT_W-1:0] longest_next;
  lndr_pkg::max_ctl_t    max_ctl;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_WRITE) && out_free;

  // out-of-range values use the last entry
  assign value_ext = WW'(value);
  assign idx_in    = (value_ext >= WW'(VALUES)) ? LAST : value_ext[IDX_W-1:0];

  // RAM port control
  assign mem_wr    = (state == S_CLEAR) || out_load;
  assign mem_waddr = (state == S_CLEAR) ? cnt : idx;
  assign mem_wdata = (state == S_CLEAR) ? '0 : fresh;
  assign mem_rd    = (state == S_SCAN);

  // peak restarts with every beat; read data is folded in the cycle after its read is issued
  assign max_ctl.clr = in_accept;
  assign max_ctl.acc = rd_vld;

  assign overall_best_next = (fresh > overall_best) ? fresh : overall_best;

  generate
    if (LEN_BITS > lndr_pkg::OUT_W) begin : g_sat
      assign longest_next = (|overall_best_next[LEN_BITS-1:lndr_pkg::OUT_W])
                          ? lndr_pkg::OUT_MAX
                          : overall_best_next[lndr_pkg::OUT_W-1:0];
    end else begin : g_ext
      assign longest_next = lndr_pkg::OUT_W'(overall_best_next);
    end
  endgenerate

  lndr_ram #(
    .WIDTH (LEN_BITS),
    .DEPTH (VALUES)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_rd),
    .rd_addr (cnt),
    .rd_data (mem_rdata)
  );

  lndr_max_unit #(
    .LEN_BITS (LEN_BITS)
  ) u_max (
    .clk   (clk),
    .ctl   (max_ctl),
    .data  (mem_rdata),
    .peak  (peak),
    .fresh (fresh)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      rd_vld       <= 1'b0;
      from_start   <= 1'b0;
      overall_best <= '0;
      out_valid    <= 1'b0;
    end else begin
      rd_vld <= mem_rd;
      // a new result replaces the old one in the same cycle it is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= from_start ? S_WRITE : S_IDLE;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            idx        <= idx_in;
            cnt        <= '0;
            from_start <= start_req;
            if (start_req) begin
              overall_best <= '0;
              state        <= S_CLEAR;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            overall_best <= overall_best_next;
            longest      <= longest_next;
            cnt          <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a beat is only taken when the sequencer is free, and work starts at once
  `LNDR_CHECK(a_accept_starts_work, in_accept |=> (state == S_SCAN || state == S_CLEAR), "beat accepted but sequencer did not start")
  // the running maximum only drops on a start beat
  `LNDR_CHECK(a_best_monotone, !(in_accept && start_req) |=> overall_best >= $past(overall_best), "running maximum decreased without start")
  // every reported length includes at least the current element
  `LNDR_CHECK(a_result_nonzero, out_valid |-> longest != '0, "zero length reported")
  // reset always begins with the table sweep and no pending result
  `LNDR_CHECK_ALL(a_reset_clear, rst |=> (state == S_CLEAR && !out_valid), "reset did not start the clearing sweep")

endmodule
